### rtl/trsa_pkg.sv
// Shared widths, register indexes, state codes and character map for the toy RSA block.
package trsa_pkg;

    localparam int DATA_W = 16;
    localparam int CHAR_W = 7;
    localparam int P_W    = 8;

    localparam logic CFG_EXP = 1'b0;
    localparam logic CFG_MOD = 1'b1;

    localparam logic [DATA_W-1:0] EXP_RESET = 16'd3;
    localparam logic [DATA_W-1:0] MOD_RESET = 16'd15;

    localparam logic [DATA_W-1:0] CHAR_OFFSET = 16'd5;
    // ceil(2^21 / 31): exact quotient by 31 for any 16-bit value
    localparam logic [18:0]       CHAR_RECIP  = 19'd67651;
    localparam logic [CHAR_W-1:0] CHAR_A      = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_NEG    = 7'd60;

    typedef enum logic [24:0] {
        S_IDLE     = 25'h0000001,
        S_SF_INIT  = 25'h0000002,
        S_SF_LOOP  = 25'h0000004,
        S_SF_DIV1  = 25'h0000008,
        S_SF_CHK2  = 25'h0000010,
        S_SQRT     = 25'h0000020,
        S_FAC_CHK  = 25'h0000040,
        S_PHI      = 25'h0000080,
        S_GCD_INIT = 25'h0000100,
        S_GCD      = 25'h0000200,
        S_GCD_STEP = 25'h0000400,
        S_INV_R1   = 25'h0000800,
        S_INV_LOOP = 25'h0001000,
        S_INV_MUL  = 25'h0002000,
        S_INV_UPD  = 25'h0004000,
        S_BAD      = 25'h0008000,
        S_DEC      = 25'h0010000,
        S_POW_BASE = 25'h0020000,
        S_POW_LOOP = 25'h0040000,
        S_POW_ACCW = 25'h0080000,
        S_POW_SQW  = 25'h0100000,
        S_MAP      = 25'h0200000,
        S_OUT      = 25'h0400000,
        S_DIV      = 25'h0800000,
        S_SPARE    = 25'h1000000
    } t_state;

    function automatic logic [CHAR_W-1:0] char_of(input logic [4:0] t);
        logic [CHAR_W-1:0] c;
        c = CHAR_A + {2'b00, t};
        unique case (t)
            5'd26:   c = 7'd32;
            5'd27:   c = 7'd34;
            5'd28:   c = 7'd44;
            5'd29:   c = 7'd46;
            5'd30:   c = 7'd39;
            default: c = CHAR_A + {2'b00, t};
        endcase
        return c;
    endfunction

endpackage

### rtl/trsa_in_if.sv
// Input channel: one ciphertext item.
interface trsa_in_if;
    logic                          valid;
    logic                          ready;
    logic [trsa_pkg::DATA_W-1:0]   cipher_value;
    logic                          last_in;

    modport source (output valid, output cipher_value, output last_in, input ready);
    modport sink   (input valid, input cipher_value, input last_in, output ready);
endinterface

### rtl/trsa_out_if.sv
// Output channel: one decrypted item with the key in use.
interface trsa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          key_valid;
    logic [trsa_pkg::DATA_W-1:0]   plain_value;
    logic [trsa_pkg::CHAR_W-1:0]   char_code;
    logic [trsa_pkg::P_W-1:0]      factor_small;
    logic [trsa_pkg::DATA_W-1:0]   factor_large;
    logic [trsa_pkg::DATA_W-1:0]   totient;
    logic [trsa_pkg::DATA_W-1:0]   private_exponent;
    logic                          last_out;

    modport source (output valid, output key_valid, output plain_value, output char_code,
                    output factor_small, output factor_large, output totient,
                    output private_exponent, output last_out, input ready);
    modport sink   (input valid, input key_valid, input plain_value, input char_code,
                    input factor_small, input factor_large, input totient,
                    input private_exponent, input last_out, output ready);
endinterface

### rtl/toy_rsa_key_derive_and_decrypt.sv
// Toy RSA key derivation and decryption top level.
// Decrypt: one item at a time on a shared 32/16 restoring divider; each private exponent bit
// costs a divide, and a set bit costs a second one.
// Key derivation after reset or a register write delays the next item; it runs trial
// division through the same divider.
// Synchronous active-low reset; the key is derived again on the first item after it.
module toy_rsa_key_derive_and_decrypt #(
    parameter int MOD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [trsa_pkg::DATA_W-1:0] i_cfg_data,
    trsa_in_if.sink                     i_in,
    trsa_out_if.source                  o_out
);

    localparam int MOD_W = (MOD_BITS < 16) ? MOD_BITS : 16;
    localparam logic [16:0] MASK17 = (17'd1 << MOD_W) - 17'd1;
    localparam logic [15:0] MOD_MASK = MASK17[15:0];

    trsa_pkg::t_state r_state, r_ret;

    logic [15:0] r_exp, r_mod;
    logic        r_key_ready, r_valid;
    logic [7:0]  r_p;
    logic [15:0] r_q, r_phi, r_d;

    logic [15:0] r_cipher;
    logic        r_last;

    logic [15:0] r_m;
    logic [8:0]  r_i;
    logic [7:0]  r_r;
    logic [15:0] r_a, r_b;
    logic signed [17:0] r_t0, r_t1;
    logic signed [19:0] r_prod;
    logic [15:0] r_acc, r_base, r_ex;
    logic [6:0]  r_code;

    logic [31:0] r_dquo;
    logic [15:0] r_drem, r_dden;
    logic [4:0]  r_dcnt;

    logic        r_out_valid, r_o_key_valid, r_o_last;
    logic [15:0] r_o_plain, r_o_q, r_o_phi, r_o_d;
    logic [6:0]  r_o_code;
    logic [7:0]  r_o_p;

    logic signed [18:0] mul_a, mul_b;
    logic signed [37:0] mul_p;
    logic [16:0] rem_sh;
    logic [17:0] dif;
    logic        ge;
    logic [15:0] sf_m;
    logic [8:0]  r_inc;
    logic [7:0]  p_try;
    logic signed [18:0] dsum;
    logic [15:0] map_x;
    logic [11:0] map_q;
    logic [16:0] map_m31;
    logic [16:0] map_d;

    always_comb begin
        r_inc = {1'b0, r_r} + 9'd1;
        map_x = r_acc - trsa_pkg::CHAR_OFFSET;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            trsa_pkg::S_SF_LOOP: begin
                mul_a = {10'b0, r_i};
                mul_b = {10'b0, r_i};
            end
            trsa_pkg::S_SQRT: begin
                mul_a = {10'b0, r_inc};
                mul_b = {10'b0, r_inc};
            end
            trsa_pkg::S_PHI: begin
                mul_a = {11'b0, r_p - 8'd1};
                mul_b = {3'b0, r_q - 16'd1};
            end
            trsa_pkg::S_INV_MUL: begin
                mul_a = {3'b0, r_dquo[15:0]};
                mul_b = {r_t1[17], r_t1};
            end
            trsa_pkg::S_POW_LOOP: begin
                mul_a = r_ex[0] ? {3'b0, r_acc} : {3'b0, r_base};
                mul_b = {3'b0, r_base};
            end
            trsa_pkg::S_POW_ACCW: begin
                mul_a = {3'b0, r_base};
                mul_b = {3'b0, r_base};
            end
            trsa_pkg::S_MAP: begin
                mul_a = {3'b0, map_x};
                mul_b = trsa_pkg::CHAR_RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        map_q   = mul_p[32:21];
        map_m31 = {map_q, 5'b0} - {5'b0, map_q};
        map_d   = {1'b0, map_x} - map_m31;
        rem_sh  = {r_drem, r_dquo[31]};
        dif     = {1'b0, rem_sh} - {2'b00, r_dden};
        ge      = ~dif[17];
        sf_m    = r_mod[0] ? r_mod : {1'b0, r_mod[15:1]};
        p_try   = r_r[0] ? r_r : r_r - 8'd1;
        dsum    = 19'(r_t0) + $signed({3'b0, r_phi});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trsa_pkg::S_IDLE;
            r_ret       <= trsa_pkg::S_IDLE;
            r_exp       <= trsa_pkg::EXP_RESET;
            r_mod       <= trsa_pkg::MOD_RESET & MOD_MASK;
            r_key_ready <= 1'b0;
            r_valid     <= 1'b0;
            r_p         <= '0;
            r_q         <= '0;
            r_phi       <= '0;
            r_d         <= '0;
            r_out_valid <= 1'b0;
            r_drem      <= '0;
            r_dcnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == trsa_pkg::CFG_EXP) begin
                    r_exp <= i_cfg_data;
                end else begin
                    r_mod <= i_cfg_data & MOD_MASK;
                end
                r_key_ready <= 1'b0;
            end
            if (r_out_valid && o_out.ready && r_state != trsa_pkg::S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (r_state != trsa_pkg::S_DIV) begin
                r_drem <= '0;
                r_dcnt <= '0;
            end
            unique case (r_state)
                trsa_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_cipher <= i_in.cipher_value;
                        r_last   <= i_in.last_in;
                        r_state  <= r_key_ready ? trsa_pkg::S_DEC : trsa_pkg::S_SF_INIT;
                    end
                end
                trsa_pkg::S_SF_INIT: begin
                    r_valid <= 1'b0;
                    r_m     <= sf_m;
                    r_i     <= 9'd3;
                    r_state <= sf_m[0] ? trsa_pkg::S_SF_LOOP : trsa_pkg::S_BAD;
                end
                trsa_pkg::S_SF_LOOP: begin
                    if (mul_p[18:0] <= {3'b0, r_m}) begin
                        r_dquo  <= {16'b0, r_m};
                        r_dden  <= {7'b0, r_i};
                        r_ret   <= trsa_pkg::S_SF_DIV1;
                        r_state <= trsa_pkg::S_DIV;
                    end else begin
                        r_r     <= '0;
                        r_state <= trsa_pkg::S_SQRT;
                    end
                end
                trsa_pkg::S_SF_DIV1: begin
                    if (r_drem == '0) begin
                        r_m     <= r_dquo[15:0];
                        r_dquo  <= {16'b0, r_dquo[15:0]};
                        r_ret   <= trsa_pkg::S_SF_CHK2;
                        r_state <= trsa_pkg::S_DIV;
                    end else begin
                        r_i     <= r_i + 9'd2;
                        r_state <= trsa_pkg::S_SF_LOOP;
                    end
                end
                trsa_pkg::S_SF_CHK2: begin
                    if (r_drem == '0) begin
                        r_state <= trsa_pkg::S_BAD;
                    end else begin
                        r_i     <= r_i + 9'd2;
                        r_state <= trsa_pkg::S_SF_LOOP;
                    end
                end
                trsa_pkg::S_SQRT: begin
                    if (mul_p[18:0] <= {3'b0, r_mod}) begin
                        r_r <= r_inc[7:0];
                    end else begin
                        r_p     <= p_try;
                        r_dquo  <= {16'b0, r_mod};
                        r_dden  <= {8'b0, p_try};
                        r_ret   <= trsa_pkg::S_FAC_CHK;
                        r_state <= trsa_pkg::S_DIV;
                    end
                end
                trsa_pkg::S_FAC_CHK: begin
                    if (r_drem != '0) begin
                        r_p     <= r_p - 8'd2;
                        r_dquo  <= {16'b0, r_mod};
                        r_dden  <= {8'b0, r_p - 8'd2};
                        r_ret   <= trsa_pkg::S_FAC_CHK;
                        r_state <= trsa_pkg::S_DIV;
                    end else begin
                        r_q     <= r_dquo[15:0];
                        r_state <= ({8'b0, r_p} == r_dquo[15:0]) ? trsa_pkg::S_BAD
                                                                  : trsa_pkg::S_PHI;
                    end
                end
                trsa_pkg::S_PHI: begin
                    r_phi   <= mul_p[15:0];
                    r_state <= trsa_pkg::S_GCD_INIT;
                end
                trsa_pkg::S_GCD_INIT: begin
                    r_a     <= r_exp;
                    r_b     <= r_phi;
                    r_state <= (r_exp == '0 || r_phi < 16'd2) ? trsa_pkg::S_BAD
                                                              : trsa_pkg::S_GCD;
                end
                trsa_pkg::S_GCD: begin
                    if (r_b == '0) begin
                        if (r_a == 16'd1) begin
                            r_dquo  <= {16'b0, r_exp};
                            r_dden  <= r_phi;
                            r_ret   <= trsa_pkg::S_INV_R1;
                            r_state <= trsa_pkg::S_DIV;
                        end else begin
                            r_state <= trsa_pkg::S_BAD;
                        end
                    end else begin
                        r_dquo  <= {16'b0, r_a};
                        r_dden  <= r_b;
                        r_ret   <= trsa_pkg::S_GCD_STEP;
                        r_state <= trsa_pkg::S_DIV;
                    end
                end
                trsa_pkg::S_GCD_STEP: begin
                    r_a     <= r_b;
                    r_b     <= r_drem;
                    r_state <= trsa_pkg::S_GCD;
                end
                trsa_pkg::S_INV_R1: begin
                    r_a     <= r_phi;
                    r_b     <= r_drem;
                    r_t0    <= '0;
                    r_t1    <= 18'sd1;
                    r_state <= trsa_pkg::S_INV_LOOP;
                end
                trsa_pkg::S_INV_LOOP: begin
                    if (r_b == '0) begin
                        r_d         <= r_t0[17] ? dsum[15:0] : r_t0[15:0];
                        r_valid     <= 1'b1;
                        r_key_ready <= 1'b1;
                        r_state     <= trsa_pkg::S_DEC;
                    end else begin
                        r_dquo  <= {16'b0, r_a};
                        r_dden  <= r_b;
                        r_ret   <= trsa_pkg::S_INV_MUL;
                        r_state <= trsa_pkg::S_DIV;
                    end
                end
                trsa_pkg::S_INV_MUL: begin
                    r_prod  <= mul_p[19:0];
                    r_a     <= r_b;
                    r_b     <= r_drem;
                    r_state <= trsa_pkg::S_INV_UPD;
                end
                trsa_pkg::S_INV_UPD: begin
                    r_t0    <= r_t1;
                    r_t1    <= 18'(20'(r_t0) - r_prod);
                    r_state <= trsa_pkg::S_INV_LOOP;
                end
                trsa_pkg::S_BAD: begin
                    r_valid     <= 1'b0;
                    r_p         <= '0;
                    r_q         <= '0;
                    r_phi       <= '0;
                    r_d         <= '0;
                    r_key_ready <= 1'b1;
                    r_state     <= trsa_pkg::S_DEC;
                end
                trsa_pkg::S_DEC: begin
                    if (r_valid) begin
                        r_acc   <= 16'd1;
                        r_ex    <= r_d;
                        r_dquo  <= {16'b0, r_cipher};
                        r_dden  <= r_mod;
                        r_ret   <= trsa_pkg::S_POW_BASE;
                        r_state <= trsa_pkg::S_DIV;
                    end else begin
                        r_acc   <= '0;
                        r_code  <= '0;
                        r_state <= trsa_pkg::S_OUT;
                    end
                end
                trsa_pkg::S_POW_BASE: begin
                    r_base  <= r_drem;
                    r_state <= trsa_pkg::S_POW_LOOP;
                end
                trsa_pkg::S_POW_LOOP: begin
                    if (r_ex == '0) begin
                        if (r_acc < trsa_pkg::CHAR_OFFSET) begin
                            r_code  <= trsa_pkg::CHAR_NEG + r_acc[6:0];
                            r_state <= trsa_pkg::S_OUT;
                        end else begin
                            r_state <= trsa_pkg::S_MAP;
                        end
                    end else begin
                        r_dquo  <= mul_p[31:0];
                        r_dden  <= r_mod;
                        r_ret   <= r_ex[0] ? trsa_pkg::S_POW_ACCW : trsa_pkg::S_POW_SQW;
                        r_state <= trsa_pkg::S_DIV;
                    end
                end
                trsa_pkg::S_POW_ACCW: begin
                    r_acc   <= r_drem;
                    r_dquo  <= mul_p[31:0];
                    r_dden  <= r_mod;
                    r_ret   <= trsa_pkg::S_POW_SQW;
                    r_state <= trsa_pkg::S_DIV;
                end
                trsa_pkg::S_POW_SQW: begin
                    r_base  <= r_drem;
                    r_ex    <= {1'b0, r_ex[15:1]};
                    r_state <= trsa_pkg::S_POW_LOOP;
                end
                trsa_pkg::S_MAP: begin
                    r_code  <= trsa_pkg::char_of(map_d[4:0]);
                    r_state <= trsa_pkg::S_OUT;
                end
                trsa_pkg::S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid   <= 1'b1;
                        r_o_key_valid <= r_valid;
                        r_o_plain     <= r_acc;
                        r_o_code      <= r_code;
                        r_o_p         <= r_p;
                        r_o_q         <= r_q;
                        r_o_phi       <= r_phi;
                        r_o_d         <= r_d;
                        r_o_last      <= r_last;
                        r_state       <= trsa_pkg::S_IDLE;
                    end
                end
                trsa_pkg::S_DIV: begin
                    r_drem <= ge ? dif[15:0] : rem_sh[15:0];
                    r_dquo <= {r_dquo[30:0], ge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= trsa_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready             = (r_state == trsa_pkg::S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.key_valid        = r_o_key_valid;
    assign o_out.plain_value      = r_o_plain;
    assign o_out.char_code        = r_o_code;
    assign o_out.factor_small     = r_o_p;
    assign o_out.factor_large     = r_o_q;
    assign o_out.totient          = r_o_phi;
    assign o_out.private_exponent = r_o_d;
    assign o_out.last_out         = r_o_last;

endmodule

### tb/toy_rsa_key_derive_and_decrypt_test.sv
// Testbench for the toy RSA block: key derivation and decryption checked against a local predictor.
module toy_rsa_key_derive_and_decrypt_test;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic                        key_valid;
        logic [trsa_pkg::DATA_W-1:0] plain_value;
        logic [trsa_pkg::CHAR_W-1:0] char_code;
        logic [trsa_pkg::P_W-1:0]    factor_small;
        logic [trsa_pkg::DATA_W-1:0] factor_large;
        logic [trsa_pkg::DATA_W-1:0] totient;
        logic [trsa_pkg::DATA_W-1:0] private_exponent;
        logic                        last_out;
    } t_plain_item;

    class decrypt_scoreboard;
        longint unsigned exp_e, mod_n;
        bit              key_known, key_ok;
        longint unsigned key_p, key_q, key_phi, key_d;
        t_plain_item     pending[$];
        int              mismatches, checked, good_keys;

        function new();
            exp_e = trsa_pkg::EXP_RESET;
            mod_n = trsa_pkg::MOD_RESET;
            key_known = 0;
        endfunction

        function void write_reg(logic idx, logic [trsa_pkg::DATA_W-1:0] value);
            if (idx == trsa_pkg::CFG_EXP) exp_e = value;
            else mod_n = value;
            key_known = 0;
        endfunction

        function bit no_square(longint unsigned n);
            longint unsigned i;
            if (n % 2 == 0) n = n / 2;
            if (n % 2 == 0) return 0;
            for (i = 3; i * i <= n; i += 2) begin
                if (n % i == 0) begin
                    n = n / i;
                    if (n % i == 0) return 0;
                end
            end
            return 1;
        endfunction

        function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
            longint unsigned t;
            if (a == 0 || b == 0) return 0;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function longint unsigned inverse_of(longint unsigned a, longint unsigned m);
            longint r0, r1, t0, t1, qt, tmp;
            r0 = m; r1 = a % m; t0 = 0; t1 = 1;
            while (r1 != 0) begin
                qt = r0 / r1;
                tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
                tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
            end
            if (t0 < 0) t0 += m;
            return t0;
        endfunction

        function void derive_key();
            longint unsigned p, q, phi;
            key_known = 1;
            key_ok = 0;
            key_p = 0; key_q = 0; key_phi = 0; key_d = 0;
            if (!no_square(mod_n)) return;
            p = 0;
            while ((p + 1) * (p + 1) <= mod_n) p++;
            if (p % 2 == 0) p--;
            while (mod_n % p != 0) p -= 2;
            q = mod_n / p;
            if (p == q) return;
            phi = (p - 1) * (q - 1);
            if (gcd_of(exp_e, phi) != 1 || phi < 2) return;
            key_ok = 1;
            key_p = p; key_q = q; key_phi = phi;
            key_d = inverse_of(exp_e, phi);
        endfunction

        function bit key_would_pass();
            derive_key();
            key_known = 0;
            return key_ok;
        endfunction

        function longint unsigned power_mod(longint unsigned b, longint unsigned x);
            longint unsigned acc;
            acc = 1 % mod_n;
            b = b % mod_n;
            while (x != 0) begin
                if (x[0]) acc = (acc * b) % mod_n;
                b = (b * b) % mod_n;
                x = x >> 1;
            end
            return acc;
        endfunction

        function logic [trsa_pkg::CHAR_W-1:0] char_for(longint unsigned plain);
            longint t;
            t = (longint'(plain) - 5) % 31;
            if (t <= 25) return 7'(65 + t);
            case (t)
                26: return 7'd32;
                27: return 7'd34;
                28: return 7'd44;
                29: return 7'd46;
                default: return 7'd39;
            endcase
        endfunction

        function void note_cipher(logic [trsa_pkg::DATA_W-1:0] cipher, logic last);
            t_plain_item e;
            longint unsigned plain;
            if (!key_known) derive_key();
            plain = 0;
            e.char_code = 0;
            if (key_ok) begin
                plain = power_mod(cipher, key_d);
                e.char_code = char_for(plain);
                good_keys++;
            end
            e.key_valid = key_ok;
            e.plain_value = plain[trsa_pkg::DATA_W-1:0];
            e.factor_small = key_p[trsa_pkg::P_W-1:0];
            e.factor_large = key_q[trsa_pkg::DATA_W-1:0];
            e.totient = key_phi[trsa_pkg::DATA_W-1:0];
            e.private_exponent = key_d[trsa_pkg::DATA_W-1:0];
            e.last_out = last;
            pending = {pending, e};
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0d expected %0d (e=%0d n=%0d)",
                     what, got, want, exp_e, mod_n);
            mismatches++;
        endtask

        task check_plain(t_plain_item g);
            t_plain_item e;
            if (pending.size() == 0) begin
                report("unexpected item", g.plain_value, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (g.key_valid !== e.key_valid) report("key_valid", g.key_valid, e.key_valid);
            if (g.plain_value !== e.plain_value)
                report("plain_value", g.plain_value, e.plain_value);
            if (g.char_code !== e.char_code) report("char_code", g.char_code, e.char_code);
            if (g.factor_small !== e.factor_small)
                report("factor_small", g.factor_small, e.factor_small);
            if (g.factor_large !== e.factor_large)
                report("factor_large", g.factor_large, e.factor_large);
            if (g.totient !== e.totient) report("totient", g.totient, e.totient);
            if (g.private_exponent !== e.private_exponent)
                report("private_exponent", g.private_exponent, e.private_exponent);
            if (g.last_out !== e.last_out) report("last_out", g.last_out, e.last_out);
        endtask
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_cfg_we = 0;
    logic                        i_cfg_idx = trsa_pkg::CFG_EXP;
    logic [trsa_pkg::DATA_W-1:0] i_cfg_data = '0;
    bit                          quiet = 0;
    int                          idle_cycles = 0;
    int                          keys_tried = 0;
    decrypt_scoreboard           sb = new();

    trsa_in_if  cipher_ch();
    trsa_out_if plain_ch();

    toy_rsa_key_derive_and_decrypt u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cipher_ch),
        .o_out      (plain_ch)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        plain_ch.ready <= quiet || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        t_plain_item g;
        if (i_rst_n && plain_ch.valid && plain_ch.ready) begin
            g.key_valid = plain_ch.key_valid;
            g.plain_value = plain_ch.plain_value;
            g.char_code = plain_ch.char_code;
            g.factor_small = plain_ch.factor_small;
            g.factor_large = plain_ch.factor_large;
            g.totient = plain_ch.totient;
            g.private_exponent = plain_ch.private_exponent;
            g.last_out = plain_ch.last_out;
            sb.check_plain(g);
        end
        if ((plain_ch.valid && plain_ch.ready) || (cipher_ch.valid && cipher_ch.ready)
                || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("toy_rsa_key_derive_and_decrypt test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_cipher(logic [trsa_pkg::DATA_W-1:0] c, logic last);
        if (!quiet && $urandom_range(99) < 11) begin
            cipher_ch.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        cipher_ch.valid <= 1;
        cipher_ch.cipher_value <= c;
        cipher_ch.last_in <= last;
        do @(posedge i_clk); while (!cipher_ch.ready);
        sb.note_cipher(c, last);
    endtask

    task end_burst();
        cipher_ch.valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task load_key(logic [trsa_pkg::DATA_W-1:0] e, logic [trsa_pkg::DATA_W-1:0] n);
        i_cfg_we <= 1;
        i_cfg_idx <= trsa_pkg::CFG_EXP;
        i_cfg_data <= e;
        @(posedge i_clk);
        sb.write_reg(trsa_pkg::CFG_EXP, e);
        i_cfg_idx <= trsa_pkg::CFG_MOD;
        i_cfg_data <= n;
        @(posedge i_clk);
        sb.write_reg(trsa_pkg::CFG_MOD, n);
        i_cfg_we <= 0;
        @(posedge i_clk);
        keys_tried++;
    endtask

    task burst(int count);
        repeat (count) send_cipher(16'($urandom()), 1'($urandom_range(1)));
        end_burst();
    endtask

    initial begin
        logic [trsa_pkg::DATA_W-1:0] e, n;
        int tries;
        cipher_ch.valid = 0;
        cipher_ch.cipher_value = '0;
        cipher_ch.last_in = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset key (e=3, n=15), then field extremes
        send_cipher(16'd0, 0);
        send_cipher(16'hFFFF, 1);
        for (int c = 1; c <= 14; c++) send_cipher(16'(c), 1'(c & 1));
        end_burst();

        load_key(16'd17, 16'd3233);
        for (int c = 0; c < 5; c++) send_cipher(16'(c * 700 + 3), 0);
        end_burst();
        load_key(16'd1, 16'hFFFF);   burst(2);
        load_key(16'hFFFF, 16'd0);   burst(1);
        load_key(16'd0, 16'd3233);   burst(1);
        load_key(16'd3, 16'd49);     burst(1);
        load_key(16'd3, 16'd3);      burst(1);
        load_key(16'd3, 16'd46340);  burst(1);

        for (int ph = 0; ph < 20; ph++) begin
            quiet = (ph == 5 || ph == 6);
            tries = 0;
            do begin
                e = 16'($urandom_range(1, 65535));
                n = (ph % 7 == 3) ? 16'($urandom()) : 16'($urandom_range(6, 46340));
                sb.exp_e = e;
                sb.mod_n = n;
                tries++;
            end while (ph % 5 != 4 && !sb.key_would_pass() && tries < 200);
            load_key(e, n);
            burst(22);
        end
        quiet = 0;

        $display("covered %0d key settings, %0d items checked, %0d with a valid key",
                 keys_tried, sb.checked, sb.good_keys);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("toy_rsa_key_derive_and_decrypt test passed");
        end else begin
            $display("toy_rsa_key_derive_and_decrypt test failed");
        end
        $finish;
    end
endmodule
